[rtl/dasd_pkg.sv]
`default_nettype none

package dasd_pkg;

  localparam int unsigned DEF_MAX_YEAR = 4095;

  // internal year width: covers any year reachable from a 12-bit year plus 2^20 days
  localparam int unsigned YW = 13;

  // floor(400 * 2^30 / 146097), year estimate from a day serial
  localparam logic [21:0] EST_K = 22'd2939805;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_SUB  = 2'd1,
    KIND_DIFF = 2'd2,
    KIND_CMP  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  eq;
    logic  gt;
    logic  lt;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [3:0]  ma;
    logic [4:0]  da;
    logic [3:0]  mb;
    logic [4:0]  db;
    logic [19:0] cnt;
  } info_t;

  localparam logic [8:0] CUM_DAYS [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // floor(x / 100) by reciprocal, exact for x < 2^14
  function automatic logic [7:0] div100(input logic [13:0] x);
    logic [30:0] p;
    p = 31'(x) * 31'd41944;
    return p[29:22];
  endfunction

  // days before month m (1..12) within a year
  function automatic logic [8:0] days_before_month(input logic [3:0] m, input logic leap);
    logic [3:0] idx;
    idx = 4'(m - 4'd1);
    return CUM_DAYS[idx] + 9'((m > 4'd2) && leap);
  endfunction

endpackage

`default_nettype wire

[rtl/dasd_dby.sv]
`default_nettype none

// Days from 0000-01-01 to Jan 1 of year_i, plus leap flag; two register stages.
module dasd_dby (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [dasd_pkg::YW-1:0] year_i,
  output logic [21:0]             days_o,
  output logic                    leap_o
);
  import dasd_pkg::*;

  logic [21:0]   t365_q;
  logic [10:0]   q4_q;
  logic [7:0]    c100_q;
  logic [5:0]    c400_q;
  logic [YW-1:0] y_q;
  logic [21:0]   days_q;
  logic          leap_q;
  logic [7:0]    c400_full;

  assign c400_full = div100(14'(year_i) + 14'd399);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t365_q <= 22'(year_i) * 22'd365;
      q4_q   <= 11'((14'(year_i) + 14'd3) >> 2);
      c100_q <= div100(14'(year_i) + 14'd99);
      c400_q <= 6'(c400_full >> 2);
      y_q    <= year_i;
      days_q <= t365_q + 22'(q4_q) - 22'(c100_q) + 22'(c400_q);
      // ceil(y/100)*100 == y exactly when y is a multiple of 100
      leap_q <= (y_q[1:0] == 2'd0) &&
                ((15'(c100_q) * 15'd100 != 15'(y_q)) ||
                 (15'(c400_q) * 15'd400 == 15'(y_q)));
    end
  end

  assign days_o = days_q;
  assign leap_o = leap_q;

endmodule

`default_nettype wire

[rtl/date_add_subtract_difference.sv]
// Gregorian date unit (proleptic calendar, year 0 leap).
// Input channel: in_valid_i/in_ready_o with kind, date A, day count and date B.
// Output channel: out_valid_o/out_ready_i with result date, signed day
// difference (A - B), compare flags and overflow.
// Dates become day serials, are added, subtracted or differenced, and
// serials go back to dates via a reciprocal year estimate that is then
// corrected against three candidate years.
// Ten register stages lie between input transfer and result valid (the
// first is loaded at the transfer edge).
// Throughput: one item per cycle unless the output stalls; the ten stages advance together.
// A stalled output freezes every stage; in_ready_o drops only while the
// output register holds an untaken result and out_ready_i is low.
// Reset clears all stage valid bits; no result is pending afterwards.
// Add/subtract results whose year falls outside 1..MAX_YEAR saturate and
// set overflow.
`default_nettype none

module date_add_subtract_difference #(
  parameter int unsigned MAX_YEAR = dasd_pkg::DEF_MAX_YEAR
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [11:0] year_a_i,
  input  logic [3:0]  month_a_i,
  input  logic [4:0]  day_a_i,
  input  logic [19:0] day_count_i,
  input  logic [11:0] year_b_i,
  input  logic [3:0]  month_b_i,
  input  logic [4:0]  day_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] result_year_o,
  output logic [3:0]  result_month_o,
  output logic [4:0]  result_day_o,
  output logic [21:0] day_difference_o,
  output logic        is_equal_o,
  output logic        is_greater_o,
  output logic        is_less_o,
  output logic        overflow_o
);
  import dasd_pkg::*;

  logic       en;
  logic [9:0] vld_q;

  assign en         = !vld_q[9] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[8:0], in_valid_i};
    end
  end

  // stage 1: capture, clamp months, compare
  info_t         info1_q, info2_q, info3_q;
  logic [YW-1:0] ya1_q, yb1_q;
  info_t         info_d;
  logic          eq_d, gt_d;

  function automatic logic [3:0] clamp_month(input logic [3:0] m);
    if (m == 4'd0) return 4'd1;
    if (m > 4'd12) return 4'd12;
    return m;
  endfunction

  always_comb begin
    eq_d = (year_a_i == year_b_i) && (month_a_i == month_b_i) && (day_a_i == day_b_i);
    gt_d = (year_a_i > year_b_i) ||
           ((year_a_i == year_b_i) && (month_a_i > month_b_i)) ||
           ((year_a_i == year_b_i) && (month_a_i == month_b_i) && (day_a_i > day_b_i));
    info_d.side.kind = kind_e'(kind_i);
    info_d.side.eq   = eq_d;
    info_d.side.gt   = gt_d;
    info_d.side.lt   = !eq_d && !gt_d;
    info_d.ma        = clamp_month(month_a_i);
    info_d.da        = day_a_i;
    info_d.mb        = clamp_month(month_b_i);
    info_d.db        = day_b_i;
    info_d.cnt       = day_count_i;
  end

  // stages 2-3: year part of both serials
  logic [21:0] days_a, days_b;
  logic        leap_a, leap_b;

  dasd_dby u_dby_a (.clk_i, .en_i(en), .year_i(ya1_q), .days_o(days_a), .leap_o(leap_a));
  dasd_dby u_dby_b (.clk_i, .en_i(en), .year_i(yb1_q), .days_o(days_b), .leap_o(leap_b));

  // stage 4: full serials
  logic [22:0] sa4_q, sb4_q;
  side_t       side4_q, side5_q, side6_q, side7_q, side8_q, side9_q;
  logic [19:0] cnt4_q;
  // stage 5: moved serial and difference
  logic [22:0] s5_q;
  logic [21:0] diff5_q, diff6_q, diff7_q, diff8_q, diff9_q;
  // stage 6: year estimate
  logic [YW-1:0] yest6_q, yest7_q, yest8_q;
  logic [21:0]   s6_q, s7_q, s8_q;
  logic          neg6_q, neg7_q, neg8_q, neg9_q;
  logic [43:0]   est_prod;

  assign est_prod = 44'(s5_q[21:0]) * 44'(EST_K);

  // stages 7-8: candidate year starts
  logic [YW-1:0] c0, c1, c2;
  logic [21:0]   dc0, dc1, dc2;
  logic          lc0, lc1, lc2;

  assign c1 = yest6_q;
  assign c2 = yest6_q + YW'(1);
  assign c0 = (yest6_q == '0) ? '0 : yest6_q - YW'(1);

  dasd_dby u_dby_c0 (.clk_i, .en_i(en), .year_i(c0), .days_o(dc0), .leap_o(lc0));
  dasd_dby u_dby_c1 (.clk_i, .en_i(en), .year_i(c1), .days_o(dc1), .leap_o(lc1));
  dasd_dby u_dby_c2 (.clk_i, .en_i(en), .year_i(c2), .days_o(dc2), .leap_o(lc2));

  // stage 9: pick year, day of year
  logic [YW-1:0] y9_q, ysel;
  logic [8:0]    doy9_q;
  logic          leap9_q, lsel;
  logic [21:0]   dsel;

  always_comb begin
    if (dc2 <= s8_q) begin
      ysel = yest8_q + YW'(1);
      dsel = dc2;
      lsel = lc2;
    end else if (dc1 <= s8_q) begin
      ysel = yest8_q;
      dsel = dc1;
      lsel = lc1;
    end else begin
      ysel = (yest8_q == '0) ? '0 : yest8_q - YW'(1);
      dsel = dc0;
      lsel = lc0;
    end
  end

  // stage 10: month and day, saturation, output register
  logic [3:0]  mon;
  logic [8:0]  mstart;
  logic        low, high;
  logic [11:0] ry_d;
  logic [3:0]  rm_d;
  logic [4:0]  rd_d;
  logic [21:0] df_d;
  logic        ovf_d;

  always_comb begin
    mon    = 4'd1;
    mstart = 9'd0;
    for (int i = 2; i <= 12; i++) begin
      if (days_before_month(4'(i), leap9_q) <= doy9_q) begin
        mon    = 4'(i);
        mstart = days_before_month(4'(i), leap9_q);
      end
    end
    low  = neg9_q || (y9_q == '0);
    high = 32'(y9_q) > MAX_YEAR;
    ry_d  = '0;
    rm_d  = '0;
    rd_d  = '0;
    df_d  = '0;
    ovf_d = 1'b0;
    case (side9_q.kind)
      KIND_ADD, KIND_SUB: begin
        if (low) begin
          ry_d  = 12'd1;
          rm_d  = 4'd1;
          rd_d  = 5'd1;
          ovf_d = 1'b1;
        end else if (high) begin
          ry_d  = 12'(MAX_YEAR);
          rm_d  = 4'd12;
          rd_d  = 5'd31;
          ovf_d = 1'b1;
        end else begin
          ry_d = 12'(y9_q);
          rm_d = mon;
          rd_d = 5'(doy9_q - mstart + 9'd1);
        end
      end
      KIND_DIFF: df_d = diff9_q;
      default:   df_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      info1_q <= info_d;
      ya1_q   <= YW'(year_a_i);
      yb1_q   <= YW'(year_b_i);
      info2_q <= info1_q;
      info3_q <= info2_q;

      sa4_q   <= 23'(days_a) + 23'(days_before_month(info3_q.ma, leap_a))
                 + 23'(info3_q.da) - 23'd1;
      sb4_q   <= 23'(days_b) + 23'(days_before_month(info3_q.mb, leap_b))
                 + 23'(info3_q.db) - 23'd1;
      side4_q <= info3_q.side;
      cnt4_q  <= info3_q.cnt;

      s5_q    <= (side4_q.kind == KIND_ADD) ? sa4_q + 23'(cnt4_q) : sa4_q - 23'(cnt4_q);
      diff5_q <= 22'(sa4_q - sb4_q);
      side5_q <= side4_q;

      yest6_q <= est_prod[30+YW-1:30];
      s6_q    <= s5_q[21:0];
      neg6_q  <= s5_q[22];
      diff6_q <= diff5_q;
      side6_q <= side5_q;

      yest7_q <= yest6_q;
      s7_q    <= s6_q;
      neg7_q  <= neg6_q;
      diff7_q <= diff6_q;
      side7_q <= side6_q;

      yest8_q <= yest7_q;
      s8_q    <= s7_q;
      neg8_q  <= neg7_q;
      diff8_q <= diff7_q;
      side8_q <= side7_q;

      y9_q    <= ysel;
      doy9_q  <= 9'(s8_q - dsel);
      leap9_q <= lsel;
      neg9_q  <= neg8_q;
      diff9_q <= diff8_q;
      side9_q <= side8_q;

      result_year_o    <= ry_d;
      result_month_o   <= rm_d;
      result_day_o     <= rd_d;
      day_difference_o <= df_d;
      is_equal_o       <= side9_q.eq;
      is_greater_o     <= side9_q.gt;
      is_less_o        <= side9_q.lt;
      overflow_o       <= ovf_d;
    end
  end

  assign out_valid_o = vld_q[9];

endmodule

`default_nettype wire

[test/date_add_subtract_difference_tb.sv]
module date_add_subtract_difference_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dasd_pkg::*;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [21:0] diff;
    logic        eq;
    logic        gt;
    logic        lt;
    logic        ovf;
  } date_res_t;

  localparam int unsigned YEAR_LIMIT = 4095;
  localparam int CUM [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = '0;
  logic [11:0] year_a_i = '0;
  logic [3:0]  month_a_i = '0;
  logic [4:0]  day_a_i = '0;
  logic [19:0] day_count_i = '0;
  logic [11:0] year_b_i = '0;
  logic [3:0]  month_b_i = '0;
  logic [4:0]  day_b_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [11:0] result_year_o;
  logic [3:0]  result_month_o;
  logic [4:0]  result_day_o;
  logic [21:0] day_difference_o;
  logic        is_equal_o, is_greater_o, is_less_o, overflow_o;

  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int n_sent = 0;

  date_add_subtract_difference dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic bit leap_year(longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic longint year_start(longint y);
    return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  function automatic longint month_start(longint y, int m);
    return CUM[m - 1] + ((m > 2 && leap_year(y)) ? 1 : 0);
  endfunction

  function automatic longint day_serial(int y, int m, int d);
    int mm;
    mm = (m < 1) ? 1 : (m > 12) ? 12 : m;
    return year_start(y) + month_start(y, mm) + d - 1;
  endfunction

  class date_scoreboard;
    date_res_t expected_q[$];
    int n_checked = 0;

    function void note_transfer(kind_e k, int ya, int ma, int da, int cnt,
                                int yb, int mb, int db);
      date_res_t r;
      longint sa, s, y, v;
      int m;
      r = '0;
      r.eq = (ya == yb) && (ma == mb) && (da == db);
      r.gt = (ya > yb) || (ya == yb && ma > mb) || (ya == yb && ma == mb && da > db);
      r.lt = !r.eq && !r.gt;
      sa = day_serial(ya, ma, da);
      if (k == KIND_ADD || k == KIND_SUB) begin
        s = (k == KIND_ADD) ? sa + cnt : sa - cnt;
        if (s < 0) begin
          r.year = 12'd1; r.month = 4'd1; r.day = 5'd1; r.ovf = 1'b1;
        end else begin
          y = (s * 400) / 146097;
          while (year_start(y + 1) <= s) y++;
          while (y > 0 && year_start(y) > s) y--;
          if (y < 1) begin
            r.year = 12'd1; r.month = 4'd1; r.day = 5'd1; r.ovf = 1'b1;
          end else if (y > YEAR_LIMIT) begin
            r.year = 12'(YEAR_LIMIT); r.month = 4'd12; r.day = 5'd31; r.ovf = 1'b1;
          end else begin
            m = 12;
            while (m > 1 && month_start(y, m) > s - year_start(y)) m--;
            r.year = 12'(y);
            r.month = 4'(m);
            r.day = 5'(s - year_start(y) - month_start(y, m) + 1);
          end
        end
      end else if (k == KIND_DIFF) begin
        v = sa - day_serial(yb, mb, db);
        if (v > 2097151) v = 2097151;
        if (v < -2097151) v = -2097151;
        r.diff = v[21:0];
      end
      expected_q.push_back(r);
    endfunction

    task check_result(date_res_t got);
      date_res_t w;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
        return;
      end
      w = expected_q.pop_front();
      n_checked++;
      if (got.year !== w.year) report_mismatch("result_year", got.year, w.year);
      if (got.month !== w.month) report_mismatch("result_month", got.month, w.month);
      if (got.day !== w.day) report_mismatch("result_day", got.day, w.day);
      if (got.diff !== w.diff)
        report_mismatch("day_difference", $signed(got.diff), $signed(w.diff));
      if (got.eq !== w.eq) report_mismatch("is_equal", got.eq, w.eq);
      if (got.gt !== w.gt) report_mismatch("is_greater", got.gt, w.gt);
      if (got.lt !== w.lt) report_mismatch("is_less", got.lt, w.lt);
      if (got.ovf !== w.ovf) report_mismatch("overflow", got.ovf, w.ovf);
    endtask
  endclass

  date_scoreboard sb = new();

  // receiver: random stall, check on each output transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result({result_year_o, result_month_o, result_day_o, day_difference_o,
                       is_equal_o, is_greater_o, is_less_o, overflow_o});
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(kind_e k, int ya, int ma, int da, int cnt,
                           int yb, int mb, int db);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    year_a_i <= 12'(ya); month_a_i <= 4'(ma); day_a_i <= 5'(da);
    day_count_i <= 20'(cnt);
    year_b_i <= 12'(yb); month_b_i <= 4'(mb); day_b_i <= 5'(db);
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_transfer(k, ya, ma, da, cnt, yb, mb, db);
    n_sent++;
  endtask

  task automatic send_random();
    kind_e k;
    int ya, yb, cnt;
    k = kind_e'($urandom_range(3));
    ya = ($urandom_range(9) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 2400);
    yb = ($urandom_range(3) == 0) ? ya : $urandom_range(1, 4095);
    case ($urandom_range(3))
      0: cnt = $urandom_range(400);
      1: cnt = $urandom_range(40000);
      2: cnt = $urandom_range(1048575);
      default: cnt = $urandom_range(1048575, 1040000);
    endcase
    if ($urandom_range(9) == 0)
      send_item(k, $urandom_range(4095), $urandom_range(15), $urandom_range(31), cnt,
                $urandom_range(4095), $urandom_range(15), $urandom_range(31));
    else
      send_item(k, ya, $urandom_range(1, 12), $urandom_range(1, 28) + $urandom_range(3),
                cnt, yb, $urandom_range(1, 12), $urandom_range(1, 31));
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, every kind, leap days, odd months/days, saturation
    send_item(KIND_ADD, 2000, 2, 28, 1, 2000, 2, 28);
    send_item(KIND_ADD, 1900, 2, 28, 1, 1900, 3, 1);
    send_item(KIND_ADD, 2023, 12, 31, 0, 2024, 1, 1);
    send_item(KIND_ADD, 2023, 2, 31, 0, 2023, 3, 3);
    send_item(KIND_ADD, 2023, 3, 0, 0, 2023, 3, 0);
    send_item(KIND_ADD, 2023, 0, 15, 10, 2023, 15, 15);
    send_item(KIND_ADD, 4095, 12, 31, 1, 1, 1, 1);
    send_item(KIND_ADD, 4095, 15, 31, 1048575, 4095, 15, 31);
    send_item(KIND_SUB, 1, 1, 1, 1, 1, 1, 1);
    send_item(KIND_SUB, 1, 1, 2, 1, 1, 1, 1);
    send_item(KIND_SUB, 0, 0, 0, 0, 0, 0, 0);
    send_item(KIND_SUB, 2024, 3, 1, 1, 2024, 2, 29);
    send_item(KIND_SUB, 4095, 12, 31, 1048575, 1, 1, 1);
    send_item(KIND_SUB, 2000, 1, 1, 730119, 2000, 1, 1);
    send_item(KIND_DIFF, 4095, 12, 31, 0, 1, 1, 1);
    send_item(KIND_DIFF, 1, 1, 1, 0, 4095, 12, 31);
    send_item(KIND_DIFF, 0, 0, 0, 0, 4095, 15, 31);
    send_item(KIND_DIFF, 2024, 3, 1, 0, 2024, 2, 29);
    send_item(KIND_CMP, 2024, 5, 5, 1048575, 2024, 5, 5);
    send_item(KIND_CMP, 2024, 5, 6, 0, 2024, 5, 5);
    send_item(KIND_CMP, 2024, 4, 31, 0, 2024, 5, 1);
    send_item(KIND_CMP, 4095, 15, 31, 0, 0, 0, 0);
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 24 : 53) : 0;
      stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 24 : 53) : 0;
      repeat (332) send_random();
    end
    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("sent %0d items (all kinds, leap and out-of-range dates), checked %0d results",
             n_sent, sb.n_checked);
    if (errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS date_add_subtract_difference");
    end else begin
      $display("FAIL date_add_subtract_difference");
    end
    $finish;
  end

  initial begin
    #400us;
    $display("timeout");
    $display("FAIL date_add_subtract_difference");
    $finish;
  end

endmodule
